// ===== hw/rtl/ista_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ista_pkg;

    localparam int unsigned NUM_SLOTS = 4096;
    localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
    localparam int unsigned CNT_W     = SLOT_W + 1;
    localparam int unsigned ID_W      = 32;
    localparam int unsigned ACT_W     = 3;
    localparam int unsigned STAT_W    = 3;
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned WBIT_W    = $clog2(WORD_W);
    localparam int unsigned NUM_WORDS = NUM_SLOTS / WORD_W;
    localparam int unsigned WADDR_W   = $clog2(NUM_WORDS);

    localparam logic [ID_W-1:0] EMPTY_ID    = 32'hFFFF_FFFF;
    localparam logic [15:0]     CUSTOM_TAG  = 16'h8000;
    localparam logic [ID_W-1:0] CUSTOM_BASE = 32'h8000_0000;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOOKUP     = 3'd0,
        ACT_INSERT     = 3'd1,
        ACT_DELETE     = 3'd2,
        ACT_GET_CUSTOM = 3'd3,
        ACT_LOAD       = 3'd4
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK          = 3'd0,
        STAT_EXISTS      = 3'd1,
        STAT_FULL        = 3'd2,
        STAT_INVALID     = 3'd3,
        STAT_NOT_FOUND   = 3'd4,
        STAT_NOT_ON_CARD = 3'd5,
        STAT_POOL_EMPTY  = 3'd6,
        STAT_DUPLICATE   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        SLOT_ZERO,
        SLOT_TGT,
        SLOT_HIT
    } slot_sel_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_WSCAN,
        S_CS_RD,
        S_CS_BW,
        S_CS_PW,
        S_F_RD,
        S_F_WR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic      latch;
        logic      clr_run;
        logic      scan_run;
        logic      wscan_run;
        logic      wscan_pool;
        logic      cs_rd;
        logic      cs_bw;
        logic      cs_pw;
        logic      f_rd;
        logic      f_wr;
        logic      resp;
        status_t   status;
        slot_sel_t slot_sel;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    id_empty;
        logic    slot_bad;
        logic    clr_done;
        logic    scan_done;
        logic    scan_hit;
        logic    hit_card;
        logic    hit_other;
        logic    wscan_done;
        logic    wscan_found;
        logic    out_free;
    } flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ista_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ista_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ista_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ista_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ista_pkg::flags_t flags,
    output ista_pkg::cmd_t        cmd
);

    ista_pkg::state_t    state_reg, state_next;
    ista_pkg::status_t   stat_reg, stat_next;
    ista_pkg::slot_sel_t sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ista_pkg::S_CLEAR;
            stat_reg  <= ista_pkg::STAT_OK;
            sel_reg   <= ista_pkg::SLOT_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
            sel_reg   <= sel_next;
        end
    end

    // Next state, together with the status and slot choice of the pending result.
    always_comb
    begin
        state_next = state_reg;
        stat_next  = stat_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ista_pkg::S_CLEAR:
            begin
                if (flags.clr_done)
                begin
                    state_next = ista_pkg::S_IDLE;
                end
            end
            ista_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ista_pkg::S_DISPATCH;
                end
            end
            ista_pkg::S_DISPATCH:
            begin
                stat_next = ista_pkg::STAT_OK;
                sel_next  = ista_pkg::SLOT_ZERO;
                case (flags.action)
                    ista_pkg::ACT_LOOKUP:
                    begin
                        if (flags.id_empty)
                        begin
                            stat_next  = ista_pkg::STAT_NOT_FOUND;
                            state_next = ista_pkg::S_RESP;
                        end
                        else
                        begin
                            state_next = ista_pkg::S_SCAN;
                        end
                    end
                    ista_pkg::ACT_INSERT, ista_pkg::ACT_DELETE:
                    begin
                        if (flags.id_empty)
                        begin
                            stat_next  = ista_pkg::STAT_INVALID;
                            state_next = ista_pkg::S_RESP;
                        end
                        else
                        begin
                            state_next = ista_pkg::S_SCAN;
                        end
                    end
                    ista_pkg::ACT_GET_CUSTOM:
                    begin
                        state_next = ista_pkg::S_WSCAN;
                    end
                    ista_pkg::ACT_LOAD:
                    begin
                        if (flags.slot_bad)
                        begin
                            stat_next  = ista_pkg::STAT_INVALID;
                            state_next = ista_pkg::S_RESP;
                        end
                        else
                        begin
                            sel_next = ista_pkg::SLOT_TGT;
                            if (flags.id_empty)
                            begin
                                state_next = ista_pkg::S_CS_RD;
                            end
                            else
                            begin
                                state_next = ista_pkg::S_SCAN;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ista_pkg::S_RESP;
                    end
                endcase
            end
            ista_pkg::S_SCAN:
            begin
                if (flags.scan_done)
                begin
                    case (flags.action)
                        ista_pkg::ACT_LOOKUP:
                        begin
                            state_next = ista_pkg::S_RESP;
                            if (flags.scan_hit)
                            begin
                                sel_next = ista_pkg::SLOT_HIT;
                            end
                            else
                            begin
                                stat_next = ista_pkg::STAT_NOT_FOUND;
                            end
                        end
                        ista_pkg::ACT_INSERT:
                        begin
                            if (flags.scan_hit)
                            begin
                                stat_next  = ista_pkg::STAT_EXISTS;
                                state_next = ista_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = ista_pkg::S_WSCAN;
                            end
                        end
                        ista_pkg::ACT_DELETE:
                        begin
                            if (!flags.scan_hit)
                            begin
                                stat_next  = ista_pkg::STAT_NOT_FOUND;
                                state_next = ista_pkg::S_RESP;
                            end
                            else if (!flags.hit_card)
                            begin
                                stat_next  = ista_pkg::STAT_NOT_ON_CARD;
                                sel_next   = ista_pkg::SLOT_HIT;
                                state_next = ista_pkg::S_RESP;
                            end
                            else
                            begin
                                sel_next   = ista_pkg::SLOT_HIT;
                                state_next = ista_pkg::S_CS_RD;
                            end
                        end
                        default:
                        begin
                            if (flags.scan_hit && flags.hit_other)
                            begin
                                stat_next  = ista_pkg::STAT_DUPLICATE;
                                state_next = ista_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = ista_pkg::S_CS_RD;
                            end
                        end
                    endcase
                end
            end
            ista_pkg::S_WSCAN:
            begin
                if (flags.wscan_done)
                begin
                    if (flags.action == ista_pkg::ACT_GET_CUSTOM)
                    begin
                        state_next = ista_pkg::S_RESP;
                        if (!flags.wscan_found)
                        begin
                            stat_next = ista_pkg::STAT_POOL_EMPTY;
                        end
                    end
                    else if (flags.wscan_found)
                    begin
                        sel_next   = ista_pkg::SLOT_TGT;
                        state_next = ista_pkg::S_F_RD;
                    end
                    else
                    begin
                        stat_next  = ista_pkg::STAT_FULL;
                        state_next = ista_pkg::S_RESP;
                    end
                end
            end
            ista_pkg::S_CS_RD:
            begin
                state_next = ista_pkg::S_CS_BW;
            end
            ista_pkg::S_CS_BW:
            begin
                state_next = ista_pkg::S_CS_PW;
            end
            ista_pkg::S_CS_PW:
            begin
                if (flags.action == ista_pkg::ACT_LOAD && !flags.id_empty)
                begin
                    state_next = ista_pkg::S_F_RD;
                end
                else
                begin
                    state_next = ista_pkg::S_RESP;
                end
            end
            ista_pkg::S_F_RD:
            begin
                state_next = ista_pkg::S_F_WR;
            end
            ista_pkg::S_F_WR:
            begin
                state_next = ista_pkg::S_RESP;
            end
            ista_pkg::S_RESP:
            begin
                if (flags.out_free)
                begin
                    state_next = ista_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ista_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.status   = stat_reg;
        cmd.slot_sel = sel_reg;
        in_ready     = 1'b0;
        unique case (state_reg)
            ista_pkg::S_CLEAR:    cmd.clr_run = 1'b1;
            ista_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            ista_pkg::S_SCAN:     cmd.scan_run = 1'b1;
            ista_pkg::S_WSCAN:
            begin
                cmd.wscan_run  = 1'b1;
                cmd.wscan_pool = (flags.action == ista_pkg::ACT_GET_CUSTOM);
            end
            ista_pkg::S_CS_RD:    cmd.cs_rd = 1'b1;
            ista_pkg::S_CS_BW:    cmd.cs_bw = 1'b1;
            ista_pkg::S_CS_PW:    cmd.cs_pw = 1'b1;
            ista_pkg::S_F_RD:     cmd.f_rd = 1'b1;
            ista_pkg::S_F_WR:     cmd.f_wr = 1'b1;
            ista_pkg::S_RESP:     cmd.resp = flags.out_free;
            default:              cmd.latch = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ista_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ista_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire ista_pkg::cmd_t                        cmd,
    output ista_pkg::flags_t                           flags,
    input  wire logic [ista_pkg::ACT_W-1:0]            action,
    input  wire logic [ista_pkg::ID_W-1:0]             id,
    input  wire logic [ista_pkg::SLOT_W-1:0]           slot_in,
    input  wire logic                                  on_card,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic      [ista_pkg::STAT_W-1:0]           status,
    output logic      [ista_pkg::SLOT_W-1:0]           slot_out,
    output logic      [ista_pkg::ID_W-1:0]             custom_id,
    output logic      [ista_pkg::CNT_W-1:0]            free_slots
);

    localparam int unsigned SW = ista_pkg::SLOT_W;
    localparam int unsigned CW = ista_pkg::CNT_W;
    localparam int unsigned WW = ista_pkg::WORD_W;
    localparam int unsigned BW = ista_pkg::WBIT_W;
    localparam int unsigned AW = ista_pkg::WADDR_W;

    function automatic logic [BW-1:0] first_zero(input logic [WW-1:0] w);
        logic [BW-1:0] r;
        r = '0;
        for (int i = WW - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = i[BW-1:0];
            end
        end
        return r;
    endfunction

    // Custom ids that land inside the pool.
    function automatic logic in_pool(input logic [ista_pkg::ID_W-1:0] v);
        return (v[31:16] == ista_pkg::CUSTOM_TAG) &&
               ({1'b0, v[15:0]} < 17'(ista_pkg::NUM_SLOTS));
    endfunction

    logic [ista_pkg::ACT_W-1:0] action_reg;
    logic [ista_pkg::ID_W-1:0]  id_reg;
    logic [SW-1:0]              slot_in_reg;
    logic                       card_reg;
    logic [SW-1:0]              tgt_reg;
    logic [CW-1:0]              empty_cnt_reg;
    logic [CW-1:0]              sc_addr_reg;
    logic                       sc_vld_reg;
    logic [SW-1:0]              sc_idx_reg;
    logic                       sc_done_reg;
    logic                       hit_reg;
    logic [SW-1:0]              hit_slot_reg;
    logic                       hit_card_reg;
    logic [AW:0]                ws_addr_reg;
    logic                       ws_vld_reg;
    logic [AW-1:0]              ws_idx_reg;
    logic                       ws_done_reg;
    logic                       ws_found_reg;
    logic [ista_pkg::ID_W-1:0]  cid_reg;
    logic [AW:0]                clr_cnt_reg;
    logic [ista_pkg::ID_W-1:0]  old_id_reg;
    logic                       old_busy_reg;
    logic                       out_valid_reg;
    logic [ista_pkg::STAT_W-1:0] status_reg;
    logic [SW-1:0]              slot_out_reg;
    logic [ista_pkg::ID_W-1:0]  custom_id_reg;
    logic [CW-1:0]              free_reg;

    logic                       ids_we, ids_re;
    logic [SW-1:0]              ids_waddr, ids_raddr;
    logic [ista_pkg::ID_W:0]    ids_wdata, ids_rdata;
    logic                       busy_we, busy_re;
    logic [AW-1:0]              busy_waddr, busy_raddr;
    logic [WW-1:0]              busy_wdata, busy_rdata;
    logic                       cust_we, cust_re;
    logic [AW-1:0]              cust_waddr, cust_raddr;
    logic [WW-1:0]              cust_wdata, cust_rdata;

    logic                       sc_issue, ws_issue, sc_match, out_free;
    logic [WW-1:0]              ws_word;
    logic [ista_pkg::ID_W-1:0]  ids_old;
    logic                       busy_old;

    assign sc_issue = cmd.scan_run && !sc_done_reg && (sc_addr_reg < CW'(ista_pkg::NUM_SLOTS));
    assign ws_issue = cmd.wscan_run && !ws_done_reg &&
                      (ws_addr_reg < (AW + 1)'(ista_pkg::NUM_WORDS));
    assign sc_match = sc_vld_reg && busy_rdata[sc_idx_reg[BW-1:0]] &&
                      (ids_rdata[ista_pkg::ID_W-1:0] == id_reg);
    assign ws_word  = cmd.wscan_pool ? cust_rdata : busy_rdata;
    assign ids_old  = ids_rdata[ista_pkg::ID_W-1:0];
    assign busy_old = busy_rdata[tgt_reg[BW-1:0]];
    assign out_free = !out_valid_reg || out_ready;

    // Memory port steering.
    always_comb
    begin
        ids_re     = sc_issue || cmd.cs_rd;
        ids_raddr  = cmd.scan_run ? sc_addr_reg[SW-1:0] : tgt_reg;
        ids_we     = cmd.f_wr;
        ids_waddr  = tgt_reg;
        ids_wdata  = {card_reg, id_reg};

        busy_re    = sc_issue || (ws_issue && !cmd.wscan_pool) || cmd.cs_rd || cmd.f_rd;
        busy_raddr = tgt_reg[SW-1:BW];
        if (cmd.scan_run)
        begin
            busy_raddr = sc_addr_reg[SW-1:BW];
        end
        else if (cmd.wscan_run)
        begin
            busy_raddr = ws_addr_reg[AW-1:0];
        end
        busy_we    = cmd.clr_run || (cmd.cs_bw && busy_old) || cmd.f_wr;
        busy_waddr = tgt_reg[SW-1:BW];
        busy_wdata = busy_rdata | (WW'(1) << tgt_reg[BW-1:0]);
        if (cmd.clr_run)
        begin
            busy_waddr = clr_cnt_reg[AW-1:0];
            busy_wdata = '0;
        end
        else if (cmd.cs_bw)
        begin
            busy_wdata = busy_rdata & ~(WW'(1) << tgt_reg[BW-1:0]);
        end

        cust_re    = (ws_issue && cmd.wscan_pool) || cmd.cs_bw || cmd.f_rd;
        cust_raddr = id_reg[SW-1:BW];
        if (cmd.wscan_run)
        begin
            cust_raddr = ws_addr_reg[AW-1:0];
        end
        else if (cmd.cs_bw)
        begin
            cust_raddr = ids_old[SW-1:BW];
        end
        cust_we    = cmd.clr_run || (cmd.cs_pw && old_busy_reg && in_pool(old_id_reg)) ||
                     (cmd.f_wr && in_pool(id_reg));
        cust_waddr = id_reg[SW-1:BW];
        cust_wdata = cust_rdata | (WW'(1) << id_reg[BW-1:0]);
        if (cmd.clr_run)
        begin
            cust_waddr = clr_cnt_reg[AW-1:0];
            cust_wdata = '0;
        end
        else if (cmd.cs_pw)
        begin
            cust_waddr = old_id_reg[SW-1:BW];
            cust_wdata = cust_rdata & ~(WW'(1) << old_id_reg[BW-1:0]);
        end
    end

    ista_ram #(.WIDTH(ista_pkg::ID_W + 1), .DEPTH(ista_pkg::NUM_SLOTS)) u_ids (
        .clk   (clk),
        .we    (ids_we),
        .waddr (ids_waddr),
        .wdata (ids_wdata),
        .re    (ids_re),
        .raddr (ids_raddr),
        .rdata (ids_rdata)
    );

    ista_ram #(.WIDTH(WW), .DEPTH(ista_pkg::NUM_WORDS)) u_busy (
        .clk   (clk),
        .we    (busy_we),
        .waddr (busy_waddr),
        .wdata (busy_wdata),
        .re    (busy_re),
        .raddr (busy_raddr),
        .rdata (busy_rdata)
    );

    ista_ram #(.WIDTH(WW), .DEPTH(ista_pkg::NUM_WORDS)) u_pool (
        .clk   (clk),
        .we    (cust_we),
        .waddr (cust_waddr),
        .wdata (cust_wdata),
        .re    (cust_re),
        .raddr (cust_raddr),
        .rdata (cust_rdata)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_cnt_reg <= CW'(ista_pkg::NUM_SLOTS);
            sc_addr_reg   <= '0;
            sc_vld_reg    <= 1'b0;
            sc_done_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            ws_addr_reg   <= '0;
            ws_vld_reg    <= 1'b0;
            ws_done_reg   <= 1'b0;
            ws_found_reg  <= 1'b0;
            clr_cnt_reg   <= '0;
            old_busy_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_run && (clr_cnt_reg < (AW + 1)'(ista_pkg::NUM_WORDS)))
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end

            if (!cmd.scan_run)
            begin
                sc_addr_reg <= '0;
                sc_vld_reg  <= 1'b0;
                sc_done_reg <= 1'b0;
                hit_reg     <= 1'b0;
            end
            else
            begin
                sc_vld_reg <= sc_issue;
                if (sc_issue)
                begin
                    sc_addr_reg <= sc_addr_reg + 1'b1;
                end
                if (sc_match && !sc_done_reg)
                begin
                    sc_done_reg <= 1'b1;
                    hit_reg     <= 1'b1;
                end
                else if (sc_vld_reg && (sc_idx_reg == SW'(ista_pkg::NUM_SLOTS - 1)))
                begin
                    sc_done_reg <= 1'b1;
                end
            end

            if (!cmd.wscan_run)
            begin
                ws_addr_reg  <= '0;
                ws_vld_reg   <= 1'b0;
                ws_done_reg  <= 1'b0;
                ws_found_reg <= 1'b0;
            end
            else
            begin
                ws_vld_reg <= ws_issue;
                if (ws_issue)
                begin
                    ws_addr_reg <= ws_addr_reg + 1'b1;
                end
                if (ws_vld_reg && !ws_done_reg)
                begin
                    if (!(&ws_word))
                    begin
                        ws_done_reg  <= 1'b1;
                        ws_found_reg <= 1'b1;
                    end
                    else if (ws_idx_reg == AW'(ista_pkg::NUM_WORDS - 1))
                    begin
                        ws_done_reg <= 1'b1;
                    end
                end
            end

            if (cmd.cs_bw)
            begin
                old_busy_reg <= busy_old;
                if (busy_old)
                begin
                    empty_cnt_reg <= empty_cnt_reg + 1'b1;
                end
            end
            if (cmd.f_wr)
            begin
                empty_cnt_reg <= empty_cnt_reg - 1'b1;
            end

            if (cmd.resp)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg  <= action;
            id_reg      <= id;
            slot_in_reg <= slot_in;
            card_reg    <= on_card;
            tgt_reg     <= slot_in;
            cid_reg     <= ista_pkg::EMPTY_ID;
        end
        sc_idx_reg <= sc_addr_reg[SW-1:0];
        ws_idx_reg <= ws_addr_reg[AW-1:0];
        if (cmd.scan_run && sc_match && !sc_done_reg)
        begin
            hit_slot_reg <= sc_idx_reg;
            hit_card_reg <= ids_rdata[ista_pkg::ID_W];
            if (action_reg == ista_pkg::ACT_DELETE)
            begin
                tgt_reg <= sc_idx_reg;
            end
        end
        if (cmd.wscan_run && ws_vld_reg && !ws_done_reg)
        begin
            if (cmd.wscan_pool)
            begin
                // Only a word with a free number yields a custom id.
                if (!(&ws_word))
                begin
                    cid_reg <= ista_pkg::CUSTOM_BASE |
                               ista_pkg::ID_W'({ws_idx_reg, first_zero(ws_word)});
                end
            end
            else
            begin
                tgt_reg <= {ws_idx_reg, first_zero(ws_word)};
            end
        end
        if (cmd.cs_bw)
        begin
            old_id_reg <= ids_old;
        end
        if (cmd.resp)
        begin
            status_reg    <= cmd.status;
            free_reg      <= empty_cnt_reg;
            custom_id_reg <= (action_reg == ista_pkg::ACT_GET_CUSTOM) ? cid_reg : '0;
            case (cmd.slot_sel)
                ista_pkg::SLOT_TGT: slot_out_reg <= tgt_reg;
                ista_pkg::SLOT_HIT: slot_out_reg <= hit_slot_reg;
                default:            slot_out_reg <= '0;
            endcase
        end
    end

    always_comb
    begin
        flags             = '0;
        flags.action      = ista_pkg::action_t'(action_reg);
        flags.id_empty    = (id_reg == ista_pkg::EMPTY_ID);
        flags.slot_bad    = ({1'b0, slot_in_reg} >= CW'(ista_pkg::NUM_SLOTS));
        flags.clr_done    = (clr_cnt_reg == (AW + 1)'(ista_pkg::NUM_WORDS));
        flags.scan_done   = sc_done_reg;
        flags.scan_hit    = hit_reg;
        flags.hit_card    = hit_card_reg;
        flags.hit_other   = (hit_slot_reg != slot_in_reg);
        flags.wscan_done  = ws_done_reg;
        flags.wscan_found = ws_found_reg;
        flags.out_free    = out_free;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_out   = slot_out_reg;
    assign custom_id  = custom_id_reg;
    assign free_slots = free_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/id_slot_table_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Id-to-slot table of 4096 slots with a lowest-free-slot allocator and a
// custom-id pool. Each input word carries one command (lookup, insert,
// delete, get free custom id, load slot) and yields exactly one output word
// with a status, a slot, a custom id and the count of empty slots. After
// reset the block clears its occupancy and pool bitmaps and accepts no
// word during that time. Commands run one at a time. An id search reads
// the id memory one slot per cycle, so a lookup, insert, delete or load
// of a real id is a linear scan of the table. The lowest free slot and
// lowest free custom id are found by scanning 64-bit bitmap words. A
// finished output word waits in its own register, and the next input
// word is taken while it waits.
module id_slot_table_allocator_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [ista_pkg::ACT_W-1:0]        action,
    input  wire logic [ista_pkg::ID_W-1:0]         id,
    input  wire logic [ista_pkg::SLOT_W-1:0]       slot_in,
    input  wire logic                              on_card,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [ista_pkg::STAT_W-1:0]       status,
    output logic      [ista_pkg::SLOT_W-1:0]       slot_out,
    output logic      [ista_pkg::ID_W-1:0]         custom_id,
    output logic      [ista_pkg::CNT_W-1:0]        free_slots
);

    ista_pkg::cmd_t   cmd;
    ista_pkg::flags_t flags;

    // The controller sequences each command; the datapath owns the memories.
    ista_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .flags    (flags),
        .cmd      (cmd)
    );

    ista_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .flags      (flags),
        .action     (action),
        .id         (id),
        .slot_in    (slot_in),
        .on_card    (on_card),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .slot_out   (slot_out),
        .custom_id  (custom_id),
        .free_slots (free_slots)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ista_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ista_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [ista_pkg::STAT_W-1:0]  status,
    input wire logic [ista_pkg::ID_W-1:0]    custom_id,
    input wire logic [ista_pkg::CNT_W-1:0]   free_slots
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(custom_id))
        else $error("output word changed while stalled");

    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> free_slots <= ista_pkg::CNT_W'(ista_pkg::NUM_SLOTS))
        else $error("free slot count out of range");

    a_pool_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ista_pkg::STAT_POOL_EMPTY |-> custom_id == ista_pkg::EMPTY_ID)
        else $error("empty pool without empty custom id");

    a_cid_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && custom_id != '0 |->
            (custom_id[31:16] == ista_pkg::CUSTOM_TAG && status == ista_pkg::STAT_OK) ||
            (custom_id == ista_pkg::EMPTY_ID && status == ista_pkg::STAT_POOL_EMPTY))
        else $error("malformed custom id");

endmodule

bind id_slot_table_allocator_unit ista_checker u_ista_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .custom_id  (custom_id),
    .free_slots (free_slots)
);

`default_nettype wire
